FILE: design/itdt_pkg.sv
// Shared types and constants for the integer to decimal text converter.
package itdt_pkg;

  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned MAX_CHARS  = 11;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned CNT_W      = 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

  // Powers of ten, most significant first; 36 bits hold nine times the largest.
  localparam logic [35:0] POW10 [NUM_DIGITS] = '{
    36'd1000000000, 36'd100000000, 36'd10000000, 36'd1000000, 36'd100000,
    36'd10000, 36'd1000, 36'd100, 36'd10, 36'd1
  };

  typedef struct packed {
    logic                                 valid;
    logic                                 started;
    logic [31:0]                          rem;
    logic [CNT_W-1:0]                     nchar;
    logic [MAX_CHARS-1:0][CHAR_W-1:0]     chars;
  } stage_t;

endpackage

FILE: design/itdt_front.sv
// Input stage: applies the sign rule and seeds the text buffer.
module itdt_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic                   is_signed,
  input  logic [31:0]            value,
  output itdt_pkg::stage_t       dout
);

  logic neg;

  assign neg = is_signed & value[31];

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= in_valid;
    end
    if (en) begin
      dout.started <= 1'b0;
      dout.rem     <= neg ? (32'd0 - value) : value;
      dout.nchar   <= neg ? itdt_pkg::CNT_W'(1) : '0;
      dout.chars   <= neg ? {{((itdt_pkg::MAX_CHARS-1)*itdt_pkg::CHAR_W){1'b0}},
                             itdt_pkg::CHAR_MINUS}
                          : '0;
    end
  end

endmodule

FILE: design/itdt_cell.sv
// One digit cell: extracts the digit for its power of ten and appends it to the text.
module itdt_cell #(
  parameter int unsigned POS = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  itdt_pkg::stage_t   din,
  output itdt_pkg::stage_t   dout
);

  localparam logic [35:0] PW = itdt_pkg::POW10[POS];
  localparam bit IS_UNITS = (POS == itdt_pkg::NUM_DIGITS - 1);

  logic [3:0]  digit;
  logic [35:0] sub;
  logic        emit;

  // All nine multiples are constants, so the digit is a row of parallel compares.
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int k = 1; k < 10; k++) begin
      if ({4'b0, din.rem} >= 36'(k) * PW) begin
        digit = 4'(k);
        sub   = 36'(k) * PW;
      end
    end
    emit = din.started || (digit != 4'd0) || IS_UNITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.started <= din.started || (digit != 4'd0);
      dout.rem     <= din.rem - sub[31:0];
      if (emit) begin
        dout.nchar <= din.nchar + itdt_pkg::CNT_W'(1);
        dout.chars <= {din.chars[itdt_pkg::MAX_CHARS-2:0],
                       itdt_pkg::CHAR_ZERO + {3'b0, digit}};
      end else begin
        dout.nchar <= din.nchar;
        dout.chars <= din.chars;
      end
    end
  end

endmodule

FILE: design/itdt_emit.sv
// Output stage: holds one finished text and sends it out one character per cycle while the receiver is ready.
module itdt_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  itdt_pkg::stage_t              din,
  output logic                          ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itdt_pkg::CHAR_W-1:0]   char_code,
  output logic                          last
);

  logic [itdt_pkg::CNT_W-1:0]                          cnt;
  logic [itdt_pkg::MAX_CHARS-1:0][itdt_pkg::CHAR_W-1:0] buffer;
  logic [itdt_pkg::CNT_W-1:0]                          idx;

  // The earliest character sits highest, at index cnt-1.
  assign idx       = cnt - itdt_pkg::CNT_W'(1);
  assign out_valid = (cnt != '0);
  assign last      = (cnt == itdt_pkg::CNT_W'(1));
  assign ready     = (cnt == '0) || (out_ready && last);

  always_comb begin
    char_code = '0;
    for (int i = 0; i < itdt_pkg::MAX_CHARS; i++) begin
      if (idx == itdt_pkg::CNT_W'(i)) begin
        char_code = buffer[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ready && din.valid) begin
      cnt <= din.nchar;
    end else if (out_valid && out_ready) begin
      cnt <= idx;
    end
    if (ready && din.valid) begin
      buffer <= din.chars;
    end
  end

endmodule

FILE: design/integer_to_decimal_text.sv
// Top level of the 32-bit binary to decimal ASCII text converter.
//
// Each input item carries a 32-bit word (tdata) and a mode flag (tuser: 0 unsigned,
// 1 signed). The text leaves one character per item on the output, most significant
// first, with tlast on the final character; a negative signed word starts with '-'.
// A row of ten digit cells, one per power of ten, works out the digits, and a new
// word may enter every cycle while the row is not stalled. Sustained throughput is
// set by the output, which sends each character as its own item (1 to 11 per word);
// the next finished text is loaded in the same cycle as the previous one's last
// character leaves. The whole row stalls together while the output stage is busy.
module integer_to_decimal_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // char_code[6:0], zero[7]
  output logic        m_tlast
);

  itdt_pkg::stage_t                stages [itdt_pkg::NUM_DIGITS+1];
  logic                            en;
  logic                            emit_ready;
  logic [itdt_pkg::CHAR_W-1:0]     char_code;

  assign en       = !stages[itdt_pkg::NUM_DIGITS].valid || emit_ready;
  assign s_tready = en;
  assign m_tdata  = {1'b0, char_code};

  itdt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .is_signed (s_tuser),
    .value     (s_tdata),
    .dout      (stages[0])
  );

  for (genvar g = 0; g < itdt_pkg::NUM_DIGITS; g++) begin : g_cell
    itdt_cell #(.POS(g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (stages[g]),
      .dout (stages[g+1])
    );
  end

  itdt_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .din       (stages[itdt_pkg::NUM_DIGITS]),
    .ready     (emit_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .char_code (char_code),
    .last      (m_tlast)
  );

endmodule

FILE: tb/integer_to_decimal_text_test.sv
// Self-checking testbench for the integer to decimal text converter.
module integer_to_decimal_text_test;

  typedef enum logic {
    MODE_UNSIGNED = 1'b0,
    MODE_SIGNED   = 1'b1
  } mode_e;

  typedef struct packed {
    logic [itdt_pkg::CHAR_W-1:0] code;
    logic                        last;
  } text_char_t;

  localparam int unsigned TAIL_CYCLES = 30;
  localparam int unsigned MAX_REPORTS = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  text_char_t expected_text[$];
  int unsigned mismatches = 0;
  bit          gaps_on = 1'b1;
  int unsigned stall_left = 0;

  integer_to_decimal_text dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // Works out the decimal text of one word and queues its characters.
  function automatic void predict_text(mode_e mode, logic [31:0] word);
    logic [itdt_pkg::CHAR_W-1:0] chars [itdt_pkg::MAX_CHARS];
    logic [31:0]       magnitude;
    logic [31:0]       power;
    logic [31:0]       digit;
    int unsigned       count;
    bit                leading;
    text_char_t        c;
    count = 0;
    leading = 1'b1;
    magnitude = word;
    if (mode == MODE_SIGNED && word[31]) begin
      chars[count] = itdt_pkg::CHAR_MINUS;
      count++;
      // Unsigned wrap also gives the right magnitude for the most negative word.
      magnitude = 32'd0 - word;
    end
    power = 32'd1000000000;
    for (int i = 0; i < 10; i++) begin
      digit = magnitude / power;
      if (digit != 0) leading = 1'b0;
      if (!leading || power == 32'd1) begin
        chars[count] = itdt_pkg::CHAR_ZERO + digit[itdt_pkg::CHAR_W-1:0];
        count++;
      end
      magnitude = magnitude - digit * power;
      power = power / 32'd10;
    end
    for (int i = 0; i < count; i++) begin
      c.code = chars[i];
      c.last = (i == count - 1);
      expected_text = {expected_text, c};
    end
  endfunction

  // Offers one word and returns at the edge where it is accepted.
  task automatic send_word(mode_e mode, logic [31:0] word);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= mode;
    predict_text(mode, word);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_for_text();
    s_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_words();
    mode_e       modes [20] = '{
      MODE_UNSIGNED, MODE_SIGNED, MODE_UNSIGNED, MODE_SIGNED, MODE_SIGNED,
      MODE_UNSIGNED, MODE_SIGNED, MODE_UNSIGNED, MODE_UNSIGNED, MODE_UNSIGNED,
      MODE_UNSIGNED, MODE_UNSIGNED, MODE_UNSIGNED, MODE_UNSIGNED, MODE_UNSIGNED,
      MODE_UNSIGNED, MODE_SIGNED, MODE_SIGNED, MODE_UNSIGNED, MODE_SIGNED
    };
    logic [31:0] words [20] = '{
      32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd9,
      32'd10, 32'd99, 32'd100, 32'd999999999, 32'd1000000000,
      32'd4000000000, 32'hFFFF_FFF6, 32'hC465_3600, 32'd1000000001, 32'd9
    };
    gaps_on = 1'b1;
    foreach (words[i]) send_word(modes[i], words[i]);
    wait_for_text();
  endtask

  task automatic test_random_words();
    gaps_on = 1'b1;
    repeat (40) send_word(mode_e'($urandom_range(0, 1)), $urandom());
    wait_for_text();
  endtask

  // Spreads the digit count evenly, negative values included.
  task automatic test_digit_lengths();
    int unsigned digits;
    longint unsigned lo;
    longint unsigned hi;
    logic [31:0] word;
    mode_e       mode;
    gaps_on = 1'b1;
    repeat (40) begin
      digits = $urandom_range(1, 10);
      lo = (digits == 1) ? 0 : 1;
      for (int i = 1; i < digits; i++) lo = lo * 10;
      hi = (digits == 1) ? 9 : lo * 10 - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      word = 32'(lo + ($urandom() % (hi - lo + 1)));
      mode = mode_e'($urandom_range(0, 1));
      if (mode == MODE_SIGNED && word[31] == 1'b0 && $urandom_range(0, 1))
        word = 32'd0 - word;
      send_word(mode, word);
    end
    wait_for_text();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (30) send_word(mode_e'($urandom_range(0, 1)), $urandom());
    wait_for_text();
    gaps_on = 1'b1;
  endtask

  // Receiver: ready by default, with stalls of random length while gaps are on.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (gaps_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        note_mismatch($sformatf("unexpected item tdata=%h tlast=%b", m_tdata, m_tlast));
      end else begin
        want = expected_text.pop_front();
        if (m_tdata !== {1'b0, want.code})
          note_mismatch($sformatf("char_code expected %0d got tdata=%h", want.code, m_tdata));
        if (m_tlast !== want.last)
          note_mismatch($sformatf("last expected %b got %b", want.last, m_tlast));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_special_words();
    test_random_words();
    test_digit_lengths();
    test_back_to_back();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_text.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
